// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL of the matrix element evaluator.
// Depends on nothing; each checked module takes it by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked at every rising edge of clk while rstn is high.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked at every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ----- rtl/core/pme_pkg.sv -----
// Types and constants of the Pauli-string matrix element evaluator.
// Used by pauli_matrix_element_eval; depends on nothing.
package pme_pkg;

    // Operation codes carried in s_tuser.
    typedef enum logic [1:0] {
        OP_LOAD_MASK = 2'd0,
        OP_LOAD_TERM = 2'd1,
        OP_EVAL      = 2'd2,
        OP_NONE      = 2'd3
    } op_t;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MREAD = 5'b00010,
        ST_MSET  = 5'b00100,
        ST_TERM  = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    // Field widths.
    localparam int OP_W    = 2;
    localparam int IDX_W   = 8;
    localparam int WORD_W  = 32;
    localparam int END_W   = 9;
    localparam int CNT_W   = 7;
    localparam int MNUM_W  = 6;
    localparam int VAL_W   = 40;
    localparam int MAX_RES = 64;

    // Input word layout.
    localparam int S_IDX_LSB   = 0;
    localparam int S_FLIP_LSB  = S_IDX_LSB + IDX_W;
    localparam int S_END_LSB   = S_FLIP_LSB + WORD_W;
    localparam int S_SIGN_LSB  = S_END_LSB + END_W;
    localparam int S_COEF_LSB  = S_SIGN_LSB + WORD_W;
    localparam int S_KET_LSB   = S_COEF_LSB + WORD_W;
    localparam int S_USED_W    = S_KET_LSB + WORD_W;
    localparam int S_TDATA_W   = ((S_USED_W + 7) / 8) * 8;

    // Result word layout.
    localparam int M_USED_W  = MNUM_W + WORD_W + VAL_W;
    localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;

    // Saturation limits of the 40-bit sum.
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

endpackage

// ----- rtl/core/pauli_matrix_element_eval.sv -----
// Top level of the Pauli-string matrix element evaluator: term tables,
// sequencer and one shared parity/accumulate unit. Depends on pme_pkg.
//
// Channel  Direction  Handshake                   Content
// s_       in         s_tvalid / s_tready         load mask, load term, evaluate ket
// m_       out        m_tvalid / m_tready         one word per flip mask, tlast on final
// cfg_     in         cfg_valid / cfg_ready       mask_count register
//
// A load word is taken in the idle state. An evaluate word runs, for each mask
// in use, through a mask table read, a setup step, the term loop (one term per
// cycle through the single parity and saturating-add unit, behind the
// registered term memory read) and a step that hands the result to the output
// register. The output register waits on m_tready while the next mask is
// computed; a full output register holds the sequencer. Reset is synchronous,
// active low, and clears only control state; the tables hold nothing until
// written.
`include "assert_macros.svh"

module pauli_matrix_element_eval #(
    parameter int SPIN_BITS = 32,
    parameter int MAX_MASKS = 64,
    parameter int MAX_TERMS = 256
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration: mask_count.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pme_pkg::CNT_W-1:0]        cfg_data,
    // Input words.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // entry_index[7:0], flip_mask[39:8], term_end[48:40], sign_mask[80:49],
    // coefficient[112:81], ket_state[144:113], zero fill
    input  logic [pme_pkg::S_TDATA_W-1:0]    s_tdata,
    // operation[1:0]
    input  logic [pme_pkg::OP_W-1:0]         s_tuser,
    // Result words.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // mask_number[5:0], bra_state[37:6], element_value[77:38], zero fill
    output logic [pme_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                             m_tlast
);

    localparam int SPIN_W   = (SPIN_BITS < pme_pkg::WORD_W) ? SPIN_BITS : pme_pkg::WORD_W;
    localparam int MA       = (MAX_MASKS > 1) ? $clog2(MAX_MASKS) : 1;
    localparam int TA       = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int TEND_MAX = (MAX_TERMS < 511) ? MAX_TERMS : 511;
    localparam int TW       = $clog2(TEND_MAX + 1);
    localparam int CNT_MAX  = (MAX_MASKS < pme_pkg::MAX_RES) ? MAX_MASKS : pme_pkg::MAX_RES;
    localparam int VW       = pme_pkg::VAL_W;

    // Input fields.
    logic [pme_pkg::IDX_W-1:0]  in_idx;
    logic [SPIN_W-1:0]          in_flip;
    logic [pme_pkg::END_W-1:0]  in_end;
    logic [SPIN_W-1:0]          in_sign;
    logic [pme_pkg::WORD_W-1:0] in_coef;
    logic [SPIN_W-1:0]          in_ket;
    pme_pkg::op_t               in_op;

    assign in_idx  = s_tdata[pme_pkg::S_IDX_LSB +: pme_pkg::IDX_W];
    assign in_flip = s_tdata[pme_pkg::S_FLIP_LSB +: SPIN_W];
    assign in_end  = s_tdata[pme_pkg::S_END_LSB +: pme_pkg::END_W];
    assign in_sign = s_tdata[pme_pkg::S_SIGN_LSB +: SPIN_W];
    assign in_coef = s_tdata[pme_pkg::S_COEF_LSB +: pme_pkg::WORD_W];
    assign in_ket  = s_tdata[pme_pkg::S_KET_LSB +: SPIN_W];
    assign in_op   = pme_pkg::op_t'(s_tuser);

    // Registers.
    pme_pkg::state_t             state_reg, state_next;
    logic [pme_pkg::CNT_W-1:0]   mcount_reg;
    logic [pme_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [pme_pkg::CNT_W-1:0]   m_reg, m_next;
    logic [SPIN_W-1:0]           ket_reg, ket_next;
    logic [SPIN_W-1:0]           bra_reg, bra_next;
    logic [TW-1:0]               end_reg, end_next;
    logic [TW-1:0]               t_reg, t_next;
    logic                        pend_reg, pend_next;
    logic signed [VW-1:0]        acc_reg, acc_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic                        m_tlast_reg, m_tlast_next;
    logic [pme_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Table memories and their registered read data.
    logic [SPIN_W-1:0]           flip_mem [MAX_MASKS];
    logic [pme_pkg::END_W-1:0]   end_mem [MAX_MASKS];
    logic [SPIN_W-1:0]           sign_mem [MAX_TERMS];
    logic [pme_pkg::WORD_W-1:0]  coef_mem [MAX_TERMS];
    logic [SPIN_W-1:0]           flip_rd_reg;
    logic [pme_pkg::END_W-1:0]   end_rd_reg;
    logic [SPIN_W-1:0]           sign_rd_reg;
    logic [pme_pkg::WORD_W-1:0]  coef_rd_reg;

    logic                        in_fire;
    logic                        out_free;
    logic                        mask_wr;
    logic                        term_wr;
    logic [TW-1:0]               end_clamp;
    logic [pme_pkg::CNT_W-1:0]   cnt_clamp;
    logic                        is_last;

    // Shared unit signals.
    logic                        parity;
    logic signed [pme_pkg::WORD_W:0] term_val;
    logic signed [VW:0]          sum_wide;
    logic signed [VW-1:0]        sum_sat;

    assign s_tready  = (state_reg == pme_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign mask_wr   = in_fire && (in_op == pme_pkg::OP_LOAD_MASK)
                       && (32'(in_idx) < MAX_MASKS);
    assign term_wr   = in_fire && (in_op == pme_pkg::OP_LOAD_TERM)
                       && (32'(in_idx) < MAX_TERMS);
    assign is_last   = (m_reg == cnt_reg - pme_pkg::CNT_W'(1));

    // Stored end index, limited to the term table size.
    assign end_clamp = (32'(end_rd_reg) > MAX_TERMS) ? TW'(MAX_TERMS) : TW'(end_rd_reg);
    assign cnt_clamp = (32'(mcount_reg) > CNT_MAX) ? pme_pkg::CNT_W'(CNT_MAX) : mcount_reg;

    // Mask table: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mask_wr) begin
            flip_mem[MA'(in_idx)] <= in_flip;
            end_mem[MA'(in_idx)]  <= in_end;
        end
        flip_rd_reg <= flip_mem[MA'(m_reg)];
        end_rd_reg  <= end_mem[MA'(m_reg)];
    end

    // Term table: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (term_wr) begin
            sign_mem[TA'(in_idx)] <= in_sign;
            coef_mem[TA'(in_idx)] <= in_coef;
        end
        sign_rd_reg <= sign_mem[TA'(t_reg)];
        coef_rd_reg <= coef_mem[TA'(t_reg)];
    end

    // Shared unit: parity sign, then a saturating add into the sum.
    always_comb begin
        parity   = ^(bra_reg & sign_rd_reg);
        term_val = parity ? -$signed({coef_rd_reg[pme_pkg::WORD_W-1], coef_rd_reg})
                          : $signed({coef_rd_reg[pme_pkg::WORD_W-1], coef_rd_reg});
        sum_wide = $signed({acc_reg[VW-1], acc_reg})
                   + (VW+1)'(term_val);
        if (sum_wide[VW] != sum_wide[VW-1]) begin
            sum_sat = sum_wide[VW] ? pme_pkg::VAL_MIN : pme_pkg::VAL_MAX;
        end else begin
            sum_sat = sum_wide[VW-1:0];
        end
    end

    // Sequencer.
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        m_next        = m_reg;
        ket_next      = ket_reg;
        bra_next      = bra_reg;
        end_next      = end_reg;
        t_next        = t_reg;
        pend_next     = pend_reg;
        acc_next      = acc_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tlast_next  = m_tlast_reg;
        m_tdata_next  = m_tdata_reg;
        unique case (state_reg)
            pme_pkg::ST_IDLE: begin
                if (in_fire && (in_op == pme_pkg::OP_EVAL) && (cnt_clamp != '0)) begin
                    cnt_next   = cnt_clamp;
                    m_next     = '0;
                    ket_next   = in_ket;
                    end_next   = '0;
                    state_next = pme_pkg::ST_MREAD;
                end
            end
            pme_pkg::ST_MREAD: begin
                state_next = pme_pkg::ST_MSET;
            end
            pme_pkg::ST_MSET: begin
                // The previous mask's end is this mask's start.
                bra_next   = ket_reg ^ flip_rd_reg;
                t_next     = end_reg;
                end_next   = end_clamp;
                acc_next   = '0;
                pend_next  = 1'b0;
                state_next = pme_pkg::ST_TERM;
            end
            pme_pkg::ST_TERM: begin
                if (pend_reg) begin
                    acc_next = sum_sat;
                end
                if (t_reg < end_reg) begin
                    t_next    = t_reg + TW'(1);
                    pend_next = 1'b1;
                end else begin
                    // The last term's sum lands as the loop exits.
                    pend_next  = 1'b0;
                    state_next = pme_pkg::ST_OUT;
                end
            end
            pme_pkg::ST_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = is_last;
                    m_tdata_next  = pme_pkg::M_TDATA_W'({acc_reg,
                                                        pme_pkg::WORD_W'(bra_reg),
                                                        m_reg[pme_pkg::MNUM_W-1:0]});
                    if (is_last) begin
                        state_next = pme_pkg::ST_IDLE;
                    end else begin
                        m_next     = m_reg + pme_pkg::CNT_W'(1);
                        state_next = pme_pkg::ST_MREAD;
                    end
                end
            end
            default: begin
                state_next = pme_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pme_pkg::ST_IDLE;
            mcount_reg   <= '0;
            m_reg        <= '0;
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_reg        <= m_next;
            cnt_reg      <= cnt_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                mcount_reg <= cfg_data;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        ket_reg     <= ket_next;
        bra_reg     <= bra_next;
        end_reg     <= end_next;
        t_reg       <= t_next;
        acc_reg     <= acc_next;
        m_tlast_reg <= m_tlast_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = m_tdata_reg;

    // A pending term read exists only inside the term loop.
    `ASSERT_CLK(a_pend_in_term, aclk, aresetn, pend_reg |-> (state_reg == pme_pkg::ST_TERM), "term read pending outside the term loop")
    // The mask counter never passes the mask count of the run.
    `ASSERT_CLK(a_mask_range, aclk, aresetn, (state_reg != pme_pkg::ST_IDLE) |-> (m_reg < cnt_reg), "mask counter beyond the run")
    // A finished result waits while the output register is full.
    `ASSERT_CLK(a_out_hold, aclk, aresetn, ((state_reg == pme_pkg::ST_OUT) && !out_free) |=> (state_reg == pme_pkg::ST_OUT), "result left before output register was free")
    // A result handed over shows on the output in the next cycle.
    `ASSERT_CLK(a_out_load, aclk, aresetn, ((state_reg == pme_pkg::ST_OUT) && out_free) |=> m_tvalid, "result word was lost")

endmodule
